[rtl/ibs_pkg.sv]
// Shared types and constants for the information frame builder.
package ibs_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] STUFF_FLAG_CODE = 8'h5E;
  localparam logic [7:0] STUFF_ESC_CODE  = 8'h5D;

  localparam logic [7:0] FLAG_RESET    = 8'h7E;
  localparam logic [7:0] ESCAPE_RESET  = 8'h7D;
  localparam logic [7:0] ADDR_TX_RESET = 8'h03;
  localparam logic [7:0] ADDR_RX_RESET = 8'h01;

  typedef enum logic [2:0] {
    REG_FLAG    = 3'd0,
    REG_ESCAPE  = 3'd1,
    REG_ADDR_TX = 3'd2,
    REG_ADDR_RX = 3'd3,
    REG_ROLE    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] flag_value;
    logic [7:0] escape_value;
    logic [7:0] addr_transmitter;
    logic [7:0] addr_receiver;
    logic       role_select;
  } cfg_t;

  typedef enum logic {
    K_DATA = 1'b0,
    K_MARK = 1'b1
  } kind_t;

  typedef struct packed {
    logic       hdr;
    logic [7:0] addr;
    logic [7:0] ctrl;
    logic [7:0] data;
    logic [7:0] bcc2;
    kind_t      kind;
    logic       trailer;
  } cmd_t;

  typedef enum logic [2:0] {
    S_FLAG,
    S_ADDR,
    S_CTRL,
    S_BCC1,
    S_BODY,
    S_BCC2,
    S_CLOSE
  } slot_t;

endpackage

[rtl/ibs_cfg.sv]
// Configuration register bank.
module ibs_cfg (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output ibs_pkg::cfg_t     cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.flag_value       <= ibs_pkg::FLAG_RESET;
      cfg.escape_value     <= ibs_pkg::ESCAPE_RESET;
      cfg.addr_transmitter <= ibs_pkg::ADDR_TX_RESET;
      cfg.addr_receiver    <= ibs_pkg::ADDR_RX_RESET;
      cfg.role_select      <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ibs_pkg::REG_FLAG:    cfg.flag_value       <= cfg_data;
        ibs_pkg::REG_ESCAPE:  cfg.escape_value     <= cfg_data;
        ibs_pkg::REG_ADDR_TX: cfg.addr_transmitter <= cfg_data;
        ibs_pkg::REG_ADDR_RX: cfg.addr_receiver    <= cfg_data;
        ibs_pkg::REG_ROLE:    cfg.role_select      <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/ibs_front.sv]
// Front end: accepts payload bytes, tracks frame state, issues commands.
module ibs_front (
  input  logic              clk,
  input  logic              rst,
  input  ibs_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        data_byte,
  input  logic [7:0]        control_byte,
  input  logic              last_byte,
  input  logic              q_full,
  output logic              push,
  output ibs_pkg::cmd_t     cmd
);

  logic                     in_frame, in_frame_next;
  logic                     overflowed, overflowed_next;
  logic [7:0]               payload_xor, payload_xor_next;
  logic [ibs_pkg::CNT_W-1:0] payload_count, payload_count_next;

  logic                     accept;
  logic                     eff_ovf;
  logic [7:0]               eff_xor;
  logic [ibs_pkg::CNT_W-1:0] eff_cnt;
  logic                     at_limit;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  assign eff_ovf  = in_frame && overflowed;
  assign eff_xor  = in_frame ? payload_xor : 8'h00;
  assign eff_cnt  = in_frame ? payload_count : '0;
  assign at_limit = eff_cnt >= ibs_pkg::CNT_W'(ibs_pkg::MAX_PAYLOAD);

  always_comb begin
    in_frame_next      = in_frame;
    overflowed_next    = overflowed;
    payload_xor_next   = payload_xor;
    payload_count_next = payload_count;
    push               = 1'b0;

    cmd.hdr     = !in_frame;
    cmd.addr    = cfg.role_select ? cfg.addr_receiver : cfg.addr_transmitter;
    cmd.ctrl    = control_byte;
    cmd.data    = data_byte;
    cmd.bcc2    = eff_xor ^ data_byte;
    cmd.kind    = ibs_pkg::K_DATA;
    cmd.trailer = last_byte;

    if (accept) begin
      in_frame_next = !last_byte;
      priority if (eff_ovf) begin
        // abandoned frame: bytes are dropped silently
        push = 1'b0;
      end else if (at_limit) begin
        push            = 1'b1;
        cmd.kind        = ibs_pkg::K_MARK;
        cmd.trailer     = 1'b0;
        overflowed_next = 1'b1;
      end else begin
        push               = 1'b1;
        overflowed_next    = 1'b0;
        payload_xor_next   = eff_xor ^ data_byte;
        payload_count_next = eff_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame      <= 1'b0;
      overflowed    <= 1'b0;
      payload_xor   <= 8'h00;
      payload_count <= '0;
    end else begin
      in_frame      <= in_frame_next;
      overflowed    <= overflowed_next;
      payload_xor   <= payload_xor_next;
      payload_count <= payload_count_next;
    end
  end

endmodule

[rtl/ibs_fifo.sv]
// Command queue between front and back ends.
module ibs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ibs_pkg::cmd_t  push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output ibs_pkg::cmd_t  head
);

  ibs_pkg::cmd_t               mem [ibs_pkg::FIFO_DEPTH];
  logic [ibs_pkg::PTR_W-1:0]   wr_ptr;
  logic [ibs_pkg::PTR_W-1:0]   rd_ptr;
  logic [ibs_pkg::FILL_W-1:0]  fill;
  logic                        do_push;
  logic                        do_pop;

  assign full       = fill == ibs_pkg::FILL_W'(ibs_pkg::FIFO_DEPTH);
  assign head_valid = fill != '0;
  assign head       = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

[rtl/ibs_back.sv]
// Back end: walks each command's byte slots, stuffs, drives the output register.
module ibs_back (
  input  logic           clk,
  input  logic           rst,
  input  ibs_pkg::cfg_t  cfg,
  input  logic           head_valid,
  input  ibs_pkg::cmd_t  head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           run_last,
  output logic           frame_end,
  output logic           too_long
);

  ibs_pkg::slot_t slot, slot_next, cur_slot, adv_slot;
  logic           started, started_next;
  logic           phase, phase_next;

  logic       fire;
  logic [7:0] raw;
  logic [7:0] res_byte;
  logic       stuffable;
  logic       hit_flag;
  logic       hit_esc;
  logic       needs;
  logic       seg_done;
  logic       slot_last;
  logic       res_last;
  logic       is_mark;

  assign fire     = head_valid && (!out_valid || !out_stall);
  assign is_mark  = head.kind == ibs_pkg::K_MARK;
  assign cur_slot = started ? slot : (head.hdr ? ibs_pkg::S_FLAG : ibs_pkg::S_BODY);

  always_comb begin
    raw       = 8'h00;
    stuffable = 1'b0;
    adv_slot  = ibs_pkg::S_FLAG;
    unique case (cur_slot)
      ibs_pkg::S_FLAG: begin
        raw      = cfg.flag_value;
        adv_slot = ibs_pkg::S_ADDR;
      end
      ibs_pkg::S_ADDR: begin
        raw       = head.addr;
        stuffable = 1'b1;
        adv_slot  = ibs_pkg::S_CTRL;
      end
      ibs_pkg::S_CTRL: begin
        raw       = head.ctrl;
        stuffable = 1'b1;
        adv_slot  = ibs_pkg::S_BCC1;
      end
      ibs_pkg::S_BCC1: begin
        raw       = head.addr ^ head.ctrl;
        stuffable = 1'b1;
        adv_slot  = ibs_pkg::S_BODY;
      end
      ibs_pkg::S_BODY: begin
        raw       = is_mark ? 8'h00 : head.data;
        stuffable = !is_mark;
        adv_slot  = ibs_pkg::S_BCC2;
      end
      ibs_pkg::S_BCC2: begin
        raw       = head.bcc2;
        stuffable = 1'b1;
        adv_slot  = ibs_pkg::S_CLOSE;
      end
      ibs_pkg::S_CLOSE: begin
        raw      = cfg.flag_value;
        adv_slot = ibs_pkg::S_FLAG;
      end
      default: begin
        raw      = 8'h00;
        adv_slot = ibs_pkg::S_FLAG;
      end
    endcase
  end

  assign hit_flag  = raw == cfg.flag_value;
  assign hit_esc   = raw == cfg.escape_value;
  assign needs     = stuffable && (hit_flag || hit_esc);
  assign seg_done  = !needs || phase;
  assign slot_last = (cur_slot == ibs_pkg::S_CLOSE) ||
                     (cur_slot == ibs_pkg::S_BODY && (is_mark || !head.trailer));
  assign res_last  = seg_done && slot_last;
  assign pop       = fire && res_last;

  always_comb begin
    if (needs && !phase) begin
      res_byte = cfg.escape_value;
    end else if (needs) begin
      res_byte = hit_flag ? ibs_pkg::STUFF_FLAG_CODE : ibs_pkg::STUFF_ESC_CODE;
    end else begin
      res_byte = raw;
    end
  end

  always_comb begin
    slot_next    = slot;
    started_next = started;
    phase_next   = phase;
    if (fire) begin
      priority if (res_last) begin
        started_next = 1'b0;
        phase_next   = 1'b0;
      end else if (!seg_done) begin
        slot_next    = cur_slot;
        started_next = 1'b1;
        phase_next   = 1'b1;
      end else begin
        slot_next    = adv_slot;
        started_next = 1'b1;
        phase_next   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot    <= ibs_pkg::S_FLAG;
      started <= 1'b0;
      phase   <= 1'b0;
    end else begin
      slot    <= slot_next;
      started <= started_next;
      phase   <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte  <= res_byte;
      run_last  <= res_last;
      frame_end <= cur_slot == ibs_pkg::S_CLOSE;
      too_long  <= cur_slot == ibs_pkg::S_BODY && is_mark;
    end
  end

endmodule

[rtl/iframe_builder_with_byte_stuffing.sv]
// Top level of the stuffed information frame builder.
// The first line byte of an item passes through the command queue and then the
// output register before it is presented.
// Throughput: one line byte per cycle while out_stall is low; an item yields
// 1-2 line bytes for a middle payload byte and up to 12 on a one-byte frame.
// The byte-serial output sequencer sits behind a 4-entry command queue.
// Reset: synchronous rst clears frame state, queue and output; registers reload.
module iframe_builder_with_byte_stuffing (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic [7:0] control_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       frame_end,
  output logic       too_long
);

  ibs_pkg::cfg_t cfg;
  ibs_pkg::cmd_t push_cmd;
  ibs_pkg::cmd_t head;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          head_valid;

  ibs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ibs_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .control_byte (control_byte),
    .last_byte    (last_byte),
    .q_full       (q_full),
    .push         (push),
    .cmd          (push_cmd)
  );

  ibs_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ibs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .frame_end  (frame_end),
    .too_long   (too_long)
  );

endmodule

[rtl/ibs_checker.sv]
// Port-level checker for the frame builder, bound to the top level.
module ibs_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       frame_end,
  input logic       too_long
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("stalled output transfer changed");

  a_close_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> run_last && !too_long)
    else $error("closing flag not last of its run");

  a_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid && too_long |-> out_byte == 8'h00 && run_last)
    else $error("bad abandon marker");

  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind iframe_builder_with_byte_stuffing ibs_checker u_ibs_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_byte  (out_byte),
  .run_last  (run_last),
  .frame_end (frame_end),
  .too_long  (too_long)
);

[sim/frame_checker.sv]
// Watches the frame builder's ports, predicts the stuffed line bytes and compares them.
module frame_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic [7:0] control_byte,
  input  logic       last_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic       run_last,
  input  logic       frame_end,
  input  logic       too_long,
  output int         fail_count,
  output int         pending
);

  typedef struct packed {
    logic [7:0] octet;
    logic       run_last;
    logic       frame_end;
    logic       too_long;
  } line_t;

  ibs_pkg::cfg_t             cfg;
  logic                      in_frame;
  logic [7:0]                payload_xor;
  logic [ibs_pkg::CNT_W-1:0] payload_count;
  logic                      overflowed;

  line_t line_q[$];
  line_t step_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void close_frame();
    in_frame      = 1'b0;
    payload_xor   = '0;
    payload_count = '0;
    overflowed    = 1'b0;
  endfunction

  function automatic void put(input logic [7:0] b, input logic fe, input logic tl);
    line_t t;
    t.octet     = b;
    t.run_last  = 1'b0;
    t.frame_end = fe;
    t.too_long  = tl;
    step_q.push_back(t);
  endfunction

  function automatic void put_stuffed(input logic [7:0] b);
    if (b == cfg.flag_value) begin
      put(cfg.escape_value, 1'b0, 1'b0);
      put(ibs_pkg::STUFF_FLAG_CODE, 1'b0, 1'b0);
    end else if (b == cfg.escape_value) begin
      put(cfg.escape_value, 1'b0, 1'b0);
      put(ibs_pkg::STUFF_ESC_CODE, 1'b0, 1'b0);
    end else begin
      put(b, 1'b0, 1'b0);
    end
  endfunction

  function automatic void predict_line_bytes(input logic [7:0] d, input logic [7:0] c,
                                             input logic last);
    logic [7:0] addr;
    line_t      t;
    step_q.delete();
    if (!in_frame) begin
      addr = cfg.role_select ? cfg.addr_receiver : cfg.addr_transmitter;
      close_frame();
      in_frame = 1'b1;
      put(cfg.flag_value, 1'b0, 1'b0);
      put_stuffed(addr);
      put_stuffed(c);
      put_stuffed(addr ^ c);
    end
    if (overflowed) begin
      if (last) close_frame();
    end else if (payload_count >= ibs_pkg::MAX_PAYLOAD) begin
      // abandon marker, trailer never follows
      overflowed = 1'b1;
      put(8'h00, 1'b0, 1'b1);
      if (last) close_frame();
    end else begin
      payload_count = payload_count + 1'b1;
      payload_xor   = payload_xor ^ d;
      put_stuffed(d);
      if (last) begin
        put_stuffed(payload_xor);
        put(cfg.flag_value, 1'b1, 1'b0);
        close_frame();
      end
    end
    if (step_q.size() > 0) begin
      t = step_q.pop_back();
      t.run_last = 1'b1;
      step_q.push_back(t);
    end
    foreach (step_q[i]) line_q.push_back(step_q[i]);
  endfunction

  function automatic void write_register(input logic [2:0] idx, input logic [7:0] v);
    unique case (idx)
      ibs_pkg::REG_FLAG:    cfg.flag_value       = v;
      ibs_pkg::REG_ESCAPE:  cfg.escape_value     = v;
      ibs_pkg::REG_ADDR_TX: cfg.addr_transmitter = v;
      ibs_pkg::REG_ADDR_RX: cfg.addr_receiver    = v;
      ibs_pkg::REG_ROLE:    cfg.role_select      = v[0];
      default: ;
    endcase
  endfunction

  task automatic check_line_byte();
    line_t want;
    if (line_q.size() == 0) begin
      report_mismatch($sformatf("unexpected line byte %02h", out_byte));
    end else begin
      want = line_q.pop_front();
      if (out_byte !== want.octet)
        report_mismatch($sformatf("out_byte got %02h want %02h", out_byte, want.octet));
      if (run_last !== want.run_last)
        report_mismatch($sformatf("run_last got %b want %b", run_last, want.run_last));
      if (frame_end !== want.frame_end)
        report_mismatch($sformatf("frame_end got %b want %b", frame_end, want.frame_end));
      if (too_long !== want.too_long)
        report_mismatch($sformatf("too_long got %b want %b", too_long, want.too_long));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg.flag_value       = ibs_pkg::FLAG_RESET;
      cfg.escape_value     = ibs_pkg::ESCAPE_RESET;
      cfg.addr_transmitter = ibs_pkg::ADDR_TX_RESET;
      cfg.addr_receiver    = ibs_pkg::ADDR_RX_RESET;
      cfg.role_select      = 1'b0;
      close_frame();
      line_q.delete();
    end else begin
      if (out_valid && !out_stall) check_line_byte();
      if (cfg_write) write_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) predict_line_bytes(data_byte, control_byte, last_byte);
    end
    pending = line_q.size();
  end

endmodule

[sim/testbench.sv]
// Stimulus and verdict for the stuffed information frame builder.
module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD   = 200;
  localparam int SETTLE      = 10;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic [7:0] control_byte;
  logic       last_byte;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;
  logic       too_long;

  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  bit   idle_on = 1'b1;
  bit   hold_long = 1'b0;
  logic [7:0] cur_flag = ibs_pkg::FLAG_RESET;
  logic [7:0] cur_esc  = ibs_pkg::ESCAPE_RESET;

  always #5 clk = ~clk;

  iframe_builder_with_byte_stuffing u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .control_byte (control_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .too_long     (too_long)
  );

  frame_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .control_byte (control_byte),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .too_long     (too_long),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
        out_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [7:0] pick_byte();
    unique case ($urandom_range(0, 9))
      0:       return cur_flag;
      1:       return cur_esc;
      2:       return ibs_pkg::STUFF_FLAG_CODE;
      3:       return ibs_pkg::STUFF_ESC_CODE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data  = v;
    if (idx == ibs_pkg::REG_FLAG) cur_flag = v;
    if (idx == ibs_pkg::REG_ESCAPE) cur_esc = v;
    @(negedge clk);
    cfg_write = 1'b0;
  endtask

  task automatic set_config(input logic [7:0] flag, input logic [7:0] esc,
                            input logic [7:0] tx, input logic [7:0] rx,
                            input logic [7:0] role);
    write_reg(ibs_pkg::REG_FLAG, flag);
    write_reg(ibs_pkg::REG_ESCAPE, esc);
    write_reg(ibs_pkg::REG_ADDR_TX, tx);
    write_reg(ibs_pkg::REG_ADDR_RX, rx);
    write_reg(ibs_pkg::REG_ROLE, role);
  endtask

  // wait until every expected byte is out, then past the silent tail
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send(input logic [7:0] d, input logic [7:0] c, input logic l);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid     = 1'b1;
    data_byte    = d;
    control_byte = c;
    last_byte    = l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input int len);
    logic [7:0] ctrl;
    ctrl = pick_byte();
    for (int i = 0; i < len; i++)
      send(pick_byte(), (i == 0) ? ctrl : 8'($urandom), i == len - 1);
  endtask

  task automatic run_frames(input int n_items);
    int done;
    int len;
    done = 0;
    while (done < n_items) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      send_frame(len);
      done += len;
    end
  endtask

  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    data_byte    = '0;
    control_byte = '0;
    last_byte    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset configuration
    send(8'h00, 8'h00, 1'b1);
    send(8'hFF, 8'hFF, 1'b1);
    send(8'h7E, 8'h7D, 1'b1);
    send(8'h7D, 8'h7E, 1'b1);
    send(8'h7E, 8'hAA, 1'b0);
    send(8'h7D, 8'h55, 1'b0);
    send(8'h5E, 8'h00, 1'b0);
    send(8'h5D, 8'h00, 1'b0);
    send(8'h00, 8'h00, 1'b0);
    send(8'hFF, 8'h00, 1'b0);
    send(8'h01, 8'h00, 1'b1);
    send(8'h70, 8'h55, 1'b0);
    send(8'h0E, 8'h00, 1'b1);
    send(8'h70, 8'hAA, 1'b0);
    send(8'h0D, 8'h00, 1'b1);
    send(8'h55, 8'h0F, 1'b0);
    send(8'h55, 8'hF0, 1'b1);
    drain();

    // unused indexes must be ignored
    for (int i = ibs_pkg::REG_ROLE + 1; i < 8; i++) write_reg(3'(i), 8'($urandom));

    // extremes; role data with high bits set
    set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFE);
    run_frames(10);
    drain();

    // flag equal to escape, receiver role
    set_config(8'h55, 8'h55, 8'hAA, 8'h55, 8'h01);
    run_frames(10);
    drain();

    set_config(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00);
    run_frames(10);
    drain();

    set_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    hold_long = 1'b1;
    send_frame(20);
    run_frames(10);
    drain();

    // back to reset values, no idling to the end
    idle_on = 1'b0;
    set_config(ibs_pkg::FLAG_RESET, ibs_pkg::ESCAPE_RESET, ibs_pkg::ADDR_TX_RESET,
               ibs_pkg::ADDR_RX_RESET, 8'h00);
    run_frames(10);
    drain();

    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/ibs_pkg.sv
rtl/ibs_cfg.sv
rtl/ibs_front.sv
rtl/ibs_fifo.sv
rtl/ibs_back.sv
rtl/iframe_builder_with_byte_stuffing.sv
rtl/ibs_checker.sv
sim/frame_checker.sv
sim/testbench.sv
